// ===== sv/lgch_pkg.sv =====
// Shared widths, register codes and the sideband type of the line grid cell hit core.
// Used by lgch_div and line_grid_column_cell_hits_core. No dependencies.
package lgch_pkg;

  // Field and register widths.
  localparam int COL_W    = 12;
  localparam int ROW_W    = 16;
  localparam int CFG_W    = 32;
  localparam int SIZE_W   = 31;
  localparam int IDX_W    = 3;
  localparam int FRAC     = 16;

  // Datapath widths: x coordinates, Q32.32 line values, Q16.16 cell edges.
  localparam int SC_W     = SIZE_W + COL_W;
  localparam int XW       = 46;
  localparam int XLO_W    = 23;
  localparam int PL_W     = CFG_W + XLO_W + 1;
  localparam int PH_W     = CFG_W + XW - XLO_W;
  localparam int LW       = 80;
  localparam int EW       = 48;
  localparam int DEN_W    = SIZE_W + FRAC;
  localparam int QW       = 16;

  localparam int MAX_COLUMNS_DEF = 4096;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_SLOPE     = 3'd0,
    REG_INTERCEPT = 3'd1,
    REG_ORIGIN_X  = 3'd2,
    REG_ORIGIN_Y  = 3'd3,
    REG_CELL_SIZE = 3'd4
  } cfg_reg_t;

  // Data that rides along with an item through the row divider.
  typedef struct packed {
    logic                    bad;
    logic [COL_W-1:0]        col;
    logic signed [LW-1:0]    yl;
    logic signed [LW-1:0]    yr;
  } side_t;

endpackage

// ===== sv/line_grid_column_cell_hits_core.sv =====
// Top level of the line grid cell hit core: configuration, line evaluation, edge tests, output.
// Depends on lgch_pkg and lgch_div.
//
// Usage: write slope, intercept, origin_x, origin_y and cell_size (all Q16.16) through the
// cfg_ port while the core is idle. Each item on the in_ channel is one column index. The
// core evaluates the line at the column's left edge, divides down to a base row, and tests
// that row, the row above and the row below. Every hit cell leaves on the out_ channel as
// row and col; the final hit of a column carries out_last. A column with no hit, or one at
// or beyond MAX_COLUMNS, produces nothing.
// Pipeline: the 17-stage row divider (a sign stage plus 16 quotient bits) sits among the
// multiply, add and compare stages around it.
// Throughput: one column per cycle while each column has at most one hit and the output is
// taken; a column with several hits holds the output register until its last hit is taken.
// Reset: synchronous, active low; all pipeline valid bits clear and the registers return
// to a horizontal line through the origin with unit cells.
// Stall: while a hit is on the output and either out_ready is low or it is not the column's
// last hit, the whole pipeline holds in place and in_ready drops; no item is lost or repeated.
module line_grid_column_cell_hits_core #(
  parameter int MAX_COLUMNS = lgch_pkg::MAX_COLUMNS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lgch_pkg::IDX_W-1:0]        cfg_index,
  input  logic [lgch_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lgch_pkg::COL_W-1:0]        in_column,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lgch_pkg::ROW_W-1:0] out_row,
  output logic [lgch_pkg::COL_W-1:0]        out_col,
  output logic                              out_last
);
  import lgch_pkg::*;

  // Configuration registers.
  logic signed [CFG_W-1:0] slope_r, intercept_r, origin_x_r, origin_y_r;
  logic [SIZE_W-1:0]       cell_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_r     <= '0;
      intercept_r <= '0;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      cell_size_r <= SIZE_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOPE:     slope_r     <= cfg_wdata;
        REG_INTERCEPT: intercept_r <= cfg_wdata;
        REG_ORIGIN_X:  origin_x_r  <= cfg_wdata;
        REG_ORIGIN_Y:  origin_y_r  <= cfg_wdata;
        REG_CELL_SIZE: cell_size_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero cell size counts as one LSB (1/65536 in Q16.16).
  logic [SIZE_W-1:0]     s_eff;
  logic                  slope_zero;
  logic [DEN_W-1:0]      den;
  logic signed [XW-1:0]  s_x;
  logic signed [EW-1:0]  s_e;

  assign s_eff      = (cell_size_r == '0) ? SIZE_W'(1) : cell_size_r;
  assign slope_zero = (slope_r == '0);
  assign den        = {s_eff, {FRAC{1'b0}}};
  assign s_x        = XW'(s_eff);
  assign s_e        = EW'(s_eff);

  // Global advance: every stage moves when the output register can take an item.
  logic adv;

  // Stage 1: range check and cell_size * column.
  logic              s1_v_r, s1_bad_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [SC_W-1:0]   s1_sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r   <= in_valid;
      s1_bad_r <= (32'(in_column) >= 32'(MAX_COLUMNS));
      s1_col_r <= in_column;
      s1_sc_r  <= SC_W'(s_eff) * SC_W'(in_column);
    end
  end

  // Stage 2: left and right cell edges.
  logic                  s2_v_r, s2_bad_r;
  logic [COL_W-1:0]      s2_col_r;
  logic signed [XW-1:0]  s2_left_r, s2_right_r;
  logic signed [XW-1:0]  ox_x, sc_x;

  assign ox_x = XW'(origin_x_r);
  assign sc_x = XW'(s1_sc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r     <= s1_v_r;
      s2_bad_r   <= s1_bad_r;
      s2_col_r   <= s1_col_r;
      s2_left_r  <= ox_x + sc_x;
      s2_right_r <= ox_x + sc_x + s_x;
    end
  end

  // Stage 3: slope times each edge, split into low and high partial products.
  logic                    s3_v_r, s3_bad_r;
  logic [COL_W-1:0]        s3_col_r;
  logic signed [PL_W-1:0]  s3_pll_r, s3_plr_r;
  logic signed [PH_W-1:0]  s3_phl_r, s3_phr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r   <= s2_v_r;
      s3_bad_r <= s2_bad_r;
      s3_col_r <= s2_col_r;
      s3_pll_r <= slope_r * signed'({1'b0, s2_left_r[XLO_W-1:0]});
      s3_plr_r <= slope_r * signed'({1'b0, s2_right_r[XLO_W-1:0]});
      s3_phl_r <= slope_r * signed'(s2_left_r[XW-1:XLO_W]);
      s3_phr_r <= slope_r * signed'(s2_right_r[XW-1:XLO_W]);
    end
  end

  // Stage 4: line heights at both edges in Q32.32.
  logic                  s4_v_r, s4_bad_r;
  logic [COL_W-1:0]      s4_col_r;
  logic signed [LW-1:0]  s4_yl_r, s4_yr_r;
  logic signed [LW-1:0]  b_w;

  assign b_w = LW'(intercept_r) <<< FRAC;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r   <= s3_v_r;
      s4_bad_r <= s3_bad_r;
      s4_col_r <= s3_col_r;
      s4_yl_r  <= (LW'(s3_phl_r) <<< XLO_W) + LW'(s3_pll_r) + b_w;
      s4_yr_r  <= (LW'(s3_phr_r) <<< XLO_W) + LW'(s3_plr_r) + b_w;
    end
  end

  // Stage 5: height above the grid origin, the dividend of the row division.
  logic                  s5_v_r;
  logic signed [LW-1:0]  s5_num_r;
  side_t                 s5_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r         <= s4_v_r;
      s5_num_r       <= s4_yl_r - (LW'(origin_y_r) <<< FRAC);
      s5_side_r.bad  <= s4_bad_r;
      s5_side_r.col  <= s4_col_r;
      s5_side_r.yl   <= s4_yl_r;
      s5_side_r.yr   <= s4_yr_r;
    end
  end

  // Row division.
  logic           dv_v, dv_neg;
  logic [QW-1:0]  dv_q;
  side_t          dv_side;

  lgch_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .den      (den),
    .in_v     (s5_v_r),
    .in_num   (s5_num_r),
    .in_side  (s5_side_r),
    .out_v    (dv_v),
    .out_neg  (dv_neg),
    .out_q    (dv_q),
    .out_side (dv_side)
  );

  // Stage A: saturate the quotient and apply the sign.
  logic                     a_v_r;
  logic signed [ROW_W-1:0]  a_row_r;
  side_t                    a_side_r;
  logic [QW-1:0]            lim, q_sat;

  assign lim   = dv_neg ? QW'(32767) : QW'(32766);
  assign q_sat = (dv_q > lim) ? lim : dv_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r    <= dv_v;
      a_row_r  <= dv_neg ? ROW_W'(-q_sat) : ROW_W'(q_sat);
      a_side_r <= dv_side;
    end
  end

  // Stage B: cell_size * row.
  logic                     b_v_r;
  logic signed [ROW_W-1:0]  b_row_r;
  logic signed [EW-1:0]     b_prod_r;
  side_t                    b_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r    <= a_v_r;
      b_row_r  <= a_row_r;
      b_prod_r <= signed'({1'b0, s_eff}) * a_row_r;
      b_side_r <= a_side_r;
    end
  end

  // Stage C: bottom edge of the base row.
  logic                     c_v_r;
  logic signed [ROW_W-1:0]  c_row_r;
  logic signed [EW-1:0]     c_b0_r;
  side_t                    c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r    <= b_v_r;
      c_row_r  <= b_row_r;
      c_b0_r   <= EW'(origin_y_r) + b_prod_r;
      c_side_r <= b_side_r;
    end
  end

  // Stage D: the four horizontal edges from row-1 bottom to row+1 top, in Q32.32.
  logic                     d_v_r;
  logic signed [ROW_W-1:0]  d_row_r;
  logic signed [LW-1:0]     d_edge_r [4];
  side_t                    d_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (adv) begin
      d_v_r       <= c_v_r;
      d_row_r     <= c_row_r;
      d_edge_r[0] <= LW'(c_b0_r - s_e) <<< FRAC;
      d_edge_r[1] <= LW'(c_b0_r) <<< FRAC;
      d_edge_r[2] <= LW'(c_b0_r + s_e) <<< FRAC;
      d_edge_r[3] <= LW'(c_b0_r + s_e + s_e) <<< FRAC;
      d_side_r    <= c_side_r;
    end
  end

  // Stage E: compare both line heights against every edge and form the hit mask.
  // Mask bit 0 is the base row, bit 1 the row above, bit 2 the row below.
  logic [3:0] l_le, l_ge, r_le, r_ge;
  logic [2:0] hit_nxt;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      l_le[j] = d_side_r.yl <= d_edge_r[j];
      l_ge[j] = d_side_r.yl >= d_edge_r[j];
      r_le[j] = d_side_r.yr <= d_edge_r[j];
      r_ge[j] = d_side_r.yr >= d_edge_r[j];
    end
    for (int c = 0; c < 3; c++) begin
      int lo_e, hi_e;
      lo_e = (c == 0) ? 1 : ((c == 1) ? 2 : 0);
      hi_e = lo_e + 1;
      hit_nxt[c] = !d_side_r.bad &&
                   ((l_ge[lo_e] && l_le[hi_e]) ||
                    (r_ge[lo_e] && r_le[hi_e]) ||
                    (!slope_zero && ((l_le[lo_e] && r_ge[lo_e]) ||
                                     (r_le[lo_e] && l_ge[lo_e]))) ||
                    (!slope_zero && ((l_le[hi_e] && r_ge[hi_e]) ||
                                     (r_le[hi_e] && l_ge[hi_e]))));
    end
  end

  logic                     e_v_r;
  logic [2:0]               e_mask_r;
  logic signed [ROW_W-1:0]  e_row_r;
  logic [COL_W-1:0]         e_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (adv) begin
      e_v_r    <= d_v_r;
      e_mask_r <= hit_nxt;
      e_row_r  <= d_row_r;
      e_col_r  <= d_side_r.col;
    end
  end

  // Output register: sends the hits of one column in test order.
  logic                     emit_v_r;
  logic [2:0]               emit_mask_r;
  logic signed [ROW_W-1:0]  emit_row_r;
  logic [COL_W-1:0]         emit_col_r;
  logic [2:0]               sel;
  logic                     free;

  always_comb begin
    priority if (emit_mask_r[0]) begin
      sel     = 3'b001;
      out_row = emit_row_r;
    end else if (emit_mask_r[1]) begin
      sel     = 3'b010;
      out_row = emit_row_r + ROW_W'(1);
    end else begin
      sel     = 3'b100;
      out_row = emit_row_r - ROW_W'(1);
    end
  end

  assign out_valid = emit_v_r && (emit_mask_r != 3'b000);
  assign out_col   = emit_col_r;
  assign out_last  = ((emit_mask_r & ~sel) == 3'b000);
  assign free      = !out_valid || (out_ready && out_last);
  assign adv       = free;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_v_r    <= 1'b0;
      emit_mask_r <= 3'b000;
    end else if (adv) begin
      emit_v_r    <= e_v_r;
      emit_mask_r <= e_v_r ? e_mask_r : 3'b000;
      emit_row_r  <= e_row_r;
      emit_col_r  <= e_col_r;
    end else if (out_valid && out_ready) begin
      emit_mask_r <= emit_mask_r & ~sel;
    end
  end

  // A column with more hits pending keeps the output valid.
  a_more_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("output dropped before the last hit of a column");

  // The pipeline must not advance while hits of the current column remain.
  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |-> !in_ready)
    else $error("pipeline advanced over pending hits");

  // A held pipeline keeps the hit stage unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(e_v_r) && $stable(e_mask_r) && $stable(e_row_r))
    else $error("hit stage changed during a stall");

  // A column without hits never blocks the pipeline.
  a_empty_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit_v_r && (emit_mask_r == 3'b000) |-> in_ready)
    else $error("empty column blocked the pipeline");

endmodule

// ===== sv/lgch_div.sv =====
// Pipelined restoring divider that turns the line height into a row quotient.
// Depends on lgch_pkg; one quotient bit is resolved per register stage.
module lgch_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic [lgch_pkg::DEN_W-1:0]      den,
  input  logic                            in_v,
  input  logic signed [lgch_pkg::LW-1:0]  in_num,
  input  lgch_pkg::side_t                 in_side,
  output logic                            out_v,
  output logic                            out_neg,
  output logic [lgch_pkg::QW-1:0]         out_q,
  output lgch_pkg::side_t                 out_side
);
  import lgch_pkg::*;

  logic [LW-1:0] rem_r  [QW+1];
  logic [QW-1:0] q_r    [QW+1];
  logic          neg_r  [QW+1];
  logic          v_r    [QW+1];
  side_t         side_r [QW+1];

  // First stage takes the magnitude of the dividend.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0]    <= in_v;
      neg_r[0]  <= in_num[LW-1];
      rem_r[0]  <= in_num[LW-1] ? LW'(-in_num) : LW'(in_num);
      q_r[0]    <= '0;
      side_r[0] <= in_side;
    end
  end

  // One compare and subtract per stage, most significant quotient bit first.
  // A set top bit means the quotient does not fit and the row saturates.
  for (genvar i = 0; i < QW; i++) begin : g_step
    localparam int B = QW - 1 - i;
    logic [LW-1:0] dsh;
    logic          ge;
    logic [LW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    always_comb begin
      dsh      = LW'(den) << B;
      ge       = rem_r[i] >= dsh;
      rem_nxt  = ge ? (rem_r[i] - dsh) : rem_r[i];
      q_nxt    = q_r[i];
      q_nxt[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1]    <= v_r[i];
        rem_r[i+1]  <= rem_nxt;
        q_r[i+1]    <= q_nxt;
        neg_r[i+1]  <= neg_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_v    = v_r[QW];
  assign out_neg  = neg_r[QW];
  assign out_q    = q_r[QW];
  assign out_side = side_r[QW];

endmodule
